/* hw/rtl/srtf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_pkg: shared types and codes
// Controller commands, datapath status and fixed field widths of the scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 32;
	localparam int INFO_W       = 48;
	localparam int ENT_W        = KEY_W + INFO_W;
	localparam int WAIT_W       = 40;
	localparam int IN_W         = 64;

	// datapath operation codes
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_REJECT   = 4'd2;
	localparam logic [3:0] OP_INS      = 4'd3;
	localparam logic [3:0] OP_IDLETICK = 4'd4;
	localparam logic [3:0] OP_POP      = 4'd5;
	localparam logic [3:0] OP_UPRD     = 4'd6;
	localparam logic [3:0] OP_UPMOVE   = 4'd7;
	localparam logic [3:0] OP_UPEND    = 4'd8;
	localparam logic [3:0] OP_DNRD     = 4'd9;
	localparam logic [3:0] OP_DNMOVE   = 4'd10;
	localparam logic [3:0] OP_DNEND    = 4'd11;
	localparam logic [3:0] OP_REPUSH   = 4'd12;
	localparam logic [3:0] OP_FIN      = 4'd13;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic full;
		logic empty;
		logic hole_zero;
		logic up_less;
		logic dn_move;
		logic push_again;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

/* hw/rtl/srtf_heap_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an arrival is inserted and climbs one parent per step, or is rejected when full;
//   idle ticks advance time; a tick pops, sinks the hole and reinserts while work remains.
// Throughput: one item at a time (s_tready only while idle); the walk is set by the single
//   heap memory, one level per step (registered read, then compare and write).
// Reset: arst_n clears job count, time, wait total and the output valid;
//   heap memory contents are not cleared, entries are read only below the count.
// ----------------------------------------------------------------------------
// srtf_heap_scheduler: shortest-remaining-time-first scheduler
// Binary min-heap keyed by remaining length then job id; arrivals insert,
// ticks run the best job for one unit and reinsert it while work remains.
// ----------------------------------------------------------------------------
module srtf_heap_scheduler import srtf_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int CW       = $clog2(CAPACITY + 1),
	parameter int OUT_W    = ((16 + WAIT_W + CW + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// job_id[15:0], arrival_time[47:16], job_length[63:48]
	input  wire logic [IN_W-1:0]  s_tdata,
	// func
	input  wire logic             s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// run_id[15:0], wait_total[55:16], occupancy above, zero pad to bytes
	output logic [OUT_W-1:0]      m_tdata,
	// idle[0], rejected[1]
	output logic [1:0]            m_tuser
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: accept a transfer, then step the heap walk
	srtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// heap memory, counters and result register
	srtf_dp #(
		.CAPACITY (CAPACITY),
		.CW       (CW),
		.OUT_W    (OUT_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

/* hw/rtl/srtf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_ctrl: scheduler sequencer
// Steps insert/reject, pop/idle tick, sift-down, sift-up and result load.
// ----------------------------------------------------------------------------
module srtf_ctrl import srtf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_UP   = 3'd2;
	localparam logic [2:0] ST_UPC  = 3'd3;
	localparam logic [2:0] ST_DN   = 3'd4;
	localparam logic [2:0] ST_DNC  = 3'd5;
	localparam logic [2:0] ST_PUSH = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0] state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				if (!stat.is_tick) begin
					if (stat.full) begin
						cmd.op  = OP_REJECT;
						state_d = ST_FIN;
					end else begin
						cmd.op  = OP_INS;
						state_d = ST_UP;
					end
				end else if (stat.empty) begin
					cmd.op  = OP_IDLETICK;
					state_d = ST_FIN;
				end else begin
					cmd.op  = OP_POP;
					state_d = ST_DN;
				end
			end
			ST_UP: begin
				if (stat.hole_zero) begin
					cmd.op  = OP_UPEND;
					state_d = ST_FIN;
				end else begin
					cmd.op  = OP_UPRD;
					state_d = ST_UPC;
				end
			end
			ST_UPC: begin
				if (stat.up_less) begin
					cmd.op  = OP_UPMOVE;
					state_d = ST_UP;
				end else begin
					cmd.op  = OP_UPEND;
					state_d = ST_FIN;
				end
			end
			ST_DN: begin
				if (stat.empty) begin
					state_d = ST_PUSH;
				end else begin
					cmd.op  = OP_DNRD;
					state_d = ST_DNC;
				end
			end
			ST_DNC: begin
				if (stat.dn_move) begin
					cmd.op  = OP_DNMOVE;
					state_d = ST_DN;
				end else begin
					cmd.op  = OP_DNEND;
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (stat.push_again) begin
					cmd.op  = OP_REPUSH;
					state_d = ST_UP;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.op  = OP_FIN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/srtf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_dp: heap datapath
// Heap memory with two registered read ports, hole-based sift logic,
// time and wait counters, and the result register.
// ----------------------------------------------------------------------------
module srtf_dp import srtf_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int CW       = $clog2(CAPACITY + 1),
	parameter int OUT_W    = ((16 + WAIT_W + CW + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	input  wire logic [IN_W-1:0]   s_tdata,
	input  wire logic              s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,
	output logic [1:0]             m_tuser
);

	localparam int AW = $clog2(CAPACITY);
	localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

	logic [ENT_W-1:0] mem [CAPACITY];
	logic [ENT_W-1:0] rd_a_q, rd_b_q;
	logic [AW-1:0]    addr_a, addr_b, wr_addr;
	logic [ENT_W-1:0] wr_data;
	logic             wr_en;

	logic [CW-1:0]     count_q;
	logic [31:0]       time_q;
	logic [WAIT_W-1:0] wait_q;
	logic              in_func_q;
	logic [15:0]       in_id_q, in_len_q;
	logic [31:0]       in_arr_q;
	logic [KEY_W-1:0]  job_key_q, item_key_q;
	logic [INFO_W-1:0] job_info_q, item_info_q;
	logic [AW-1:0]     hole_q;
	logic              res_idle_q, res_rej_q;
	logic [15:0]       res_run_q;
	logic              out_valid_q;
	logic [15:0]       out_run_q;
	logic              out_idle_q, out_rej_q;
	logic [WAIT_W-1:0] out_wait_q;
	logic [CW-1:0]     out_occ_q;

	logic [CW:0]      hole_ext, left_idx, right_idx, parent_idx;
	logic             lv, rv, pick_l, pick_r;
	logic [KEY_W-1:0] best_key;
	logic [31:0]      root_arr, wait_inc;
	logic [15:0]      root_len;
	logic [WAIT_W:0]  wait_sum;

	assign hole_ext   = {{(CW + 1 - AW){1'b0}}, hole_q};
	assign left_idx   = {hole_ext[CW-1:0], 1'b1};
	assign right_idx  = left_idx + {{CW{1'b0}}, 1'b1};
	assign parent_idx = (hole_ext - {{CW{1'b0}}, 1'b1}) >> 1;

	assign lv       = left_idx < {1'b0, count_q};
	assign rv       = right_idx < {1'b0, count_q};
	assign pick_l   = lv && (rd_a_q[KEY_W-1:0] < item_key_q);
	assign best_key = pick_l ? rd_a_q[KEY_W-1:0] : item_key_q;
	assign pick_r   = rv && (rd_b_q[KEY_W-1:0] < best_key);

	// first-start wait of the job at the root
	assign root_len = rd_a_q[KEY_W +: 16];
	assign root_arr = rd_a_q[KEY_W + 16 +: 32];
	assign wait_inc = (time_q >= root_arr) ? (time_q - root_arr) : 32'd0;
	assign wait_sum = {1'b0, wait_q} + {{(WAIT_W - 31){1'b0}}, wait_inc};

	always_comb begin
		addr_a = '0;
		addr_b = count_q[AW-1:0] - {{(AW - 1){1'b0}}, 1'b1};
		case (cmd.op)
			OP_UPRD: addr_a = parent_idx[AW-1:0];
			OP_DNRD: begin
				addr_a = left_idx[AW-1:0];
				addr_b = right_idx[AW-1:0];
			end
			default: addr_a = '0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hole_q;
		wr_data = {item_info_q, item_key_q};
		case (cmd.op)
			OP_UPMOVE: begin
				wr_en   = 1'b1;
				wr_data = rd_a_q;
			end
			OP_UPEND, OP_DNEND: wr_en = 1'b1;
			OP_DNMOVE: begin
				wr_en   = 1'b1;
				wr_data = pick_r ? rd_b_q : rd_a_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	assign stat.is_tick    = in_func_q;
	assign stat.full       = (count_q >= CW'(CAPACITY));
	assign stat.empty      = (count_q == '0);
	assign stat.hole_zero  = (hole_q == '0);
	assign stat.up_less    = item_key_q < rd_a_q[KEY_W-1:0];
	assign stat.dn_move    = pick_l || pick_r;
	assign stat.push_again = job_key_q[31:16] > 16'd1;
	assign stat.out_free   = !out_valid_q || m_tready;

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				in_func_q  <= s_tuser;
				in_id_q    <= s_tdata[15:0];
				in_arr_q   <= s_tdata[47:16];
				in_len_q   <= s_tdata[63:48];
				res_idle_q <= 1'b0;
				res_rej_q  <= 1'b0;
				res_run_q  <= '0;
			end
			OP_REJECT:   res_rej_q <= 1'b1;
			OP_IDLETICK: res_idle_q <= 1'b1;
			OP_INS: begin
				item_key_q  <= {in_len_q, in_id_q};
				item_info_q <= {in_arr_q, in_len_q};
				hole_q      <= count_q[AW-1:0];
			end
			OP_POP: begin
				job_key_q   <= rd_a_q[KEY_W-1:0];
				job_info_q  <= rd_a_q[ENT_W-1:KEY_W];
				res_run_q   <= rd_a_q[15:0];
				item_key_q  <= rd_b_q[KEY_W-1:0];
				item_info_q <= rd_b_q[ENT_W-1:KEY_W];
				hole_q      <= '0;
			end
			OP_UPMOVE: hole_q <= parent_idx[AW-1:0];
			OP_DNMOVE: hole_q <= pick_r ? right_idx[AW-1:0] : left_idx[AW-1:0];
			OP_REPUSH: begin
				item_key_q  <= {job_key_q[31:16] - 16'd1, job_key_q[15:0]};
				item_info_q <= job_info_q;
				hole_q      <= count_q[AW-1:0];
			end
			OP_FIN: begin
				out_run_q  <= res_run_q;
				out_idle_q <= res_idle_q;
				out_rej_q  <= res_rej_q;
				out_wait_q <= wait_q;
				out_occ_q  <= count_q;
			end
			default: hole_q <= hole_q;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			time_q      <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_FIN) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_INS, OP_REPUSH: count_q <= count_q + {{(CW - 1){1'b0}}, 1'b1};
				OP_IDLETICK:       time_q <= time_q + 32'd1;
				OP_POP: begin
					count_q <= count_q - {{(CW - 1){1'b0}}, 1'b1};
					time_q  <= time_q + 32'd1;
					if (rd_a_q[KEY_W-1:16] == root_len) begin
						wait_q <= wait_sum[WAIT_W] ? WAIT_MAX : wait_sum[WAIT_W-1:0];
					end
				end
				default: count_q <= count_q;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_rej_q, out_idle_q};

	always_comb begin
		m_tdata = '0;
		m_tdata[15:0] = out_run_q;
		m_tdata[16 +: WAIT_W] = out_wait_q;
		m_tdata[16 + WAIT_W +: CW] = out_occ_q;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("heap count beyond capacity");
	a_wait_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op != OP_POP |=> wait_q == $past(wait_q))
		else $error("wait total moved outside a pop");
	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_POP || cmd.op == OP_IDLETICK) |=> time_q == $past(time_q) + 32'd1)
		else $error("time not advanced on tick");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_wait_q)))
		else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: shortest-remaining-time-first scheduler check
// Drives arrival and tick transfers with random gaps and stalls, predicts each
// result with a behavioural heap and compares every field in order.
// ----------------------------------------------------------------------------
module testbench;
	import srtf_pkg::*;

	localparam int CAP    = CAPACITY_DEF;
	localparam int CW     = $clog2(CAP + 1);
	localparam int OUT_W  = ((16 + WAIT_W + CW + 7) / 8) * 8;
	localparam logic FN_ARRIVE = 1'b0;
	localparam logic FN_TICK   = 1'b1;
	localparam logic [39:0] WAIT_SAT = 40'hFF_FFFF_FFFF;
	localparam int N_RANDOM    = 1000;
	localparam longint LIMIT   = 2000000;

	typedef struct packed {
		logic        idle;
		logic [15:0] run_id;
		logic        rejected;
		logic [39:0] wait_total;
		logic [6:0]  occupancy;
	} sched_res_t;

	typedef struct {
		logic        fn;
		logic [15:0] id;
		logic [31:0] arr;
		logic [15:0] len;
		logic        known;
		sched_res_t  res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	// behavioural scheduler state
	logic [31:0] hkey[CAP];
	logic [47:0] hinfo[CAP];
	int          njobs;
	logic [31:0] now_tick;
	logic [39:0] wait_acc;

	sched_res_t pending_res[$];
	int  errors = 0;
	bit  hold_off = 0;
	bit  calm = 0;
	longint cycles = 0;

	srtf_heap_scheduler i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// abort on a hung block
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void swap_slots(int a, int b);
		logic [31:0] k;
		logic [47:0] v;
		k = hkey[a]; v = hinfo[a];
		hkey[a] = hkey[b]; hinfo[a] = hinfo[b];
		hkey[b] = k; hinfo[b] = v;
	endfunction

	function automatic void heap_insert(logic [31:0] k, logic [47:0] v);
		int i;
		int p;
		i = njobs;
		njobs++;
		hkey[i] = k; hinfo[i] = v;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!(hkey[i] < hkey[p])) break;
			swap_slots(i, p);
			i = p;
		end
	endfunction

	function automatic void heap_sink();
		int i;
		int b;
		int l;
		i = 0;
		forever begin
			b = i; l = 2 * i + 1;
			if (l < njobs && hkey[l] < hkey[b]) b = l;
			if (l + 1 < njobs && hkey[l + 1] < hkey[b]) b = l + 1;
			if (b == i) break;
			swap_slots(i, b);
			i = b;
		end
	endfunction

	// advance the schedule by one transfer and return the expected result
	function automatic sched_res_t schedule_step(logic fn, logic [15:0] id,
			logic [31:0] arr, logic [15:0] len);
		sched_res_t r;
		logic [31:0] k;
		logic [47:0] v;
		logic [15:0] rem;
		logic [31:0] a;
		logic [40:0] s;
		r = '0;
		if (fn == FN_ARRIVE) begin
			if (njobs >= CAP) r.rejected = 1'b1;
			else heap_insert({len, id}, {arr, len});
		end else begin
			if (njobs == 0) r.idle = 1'b1;
			else begin
				k = hkey[0]; v = hinfo[0];
				rem = k[31:16]; a = v[47:16];
				njobs--;
				if (njobs > 0) begin
					hkey[0] = hkey[njobs]; hinfo[0] = hinfo[njobs];
					heap_sink();
				end
				// first start: charge the wait since arrival
				if (rem == v[15:0]) begin
					s = {1'b0, wait_acc} + ((now_tick >= a) ? 41'(now_tick - a) : 41'd0);
					wait_acc = (s > {1'b0, WAIT_SAT}) ? WAIT_SAT : s[39:0];
				end
				r.run_id = k[15:0];
				if (rem > 16'd1) heap_insert({rem - 16'd1, k[15:0]}, v);
			end
			now_tick = now_tick + 32'd1;
		end
		r.wait_total = wait_acc;
		r.occupancy = 7'(njobs);
		return r;
	endfunction

	task automatic send_item(logic fn, logic [15:0] id, logic [31:0] arr, logic [15:0] len,
			bit known, sched_res_t res);
		sched_res_t p;
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {len, arr, id};
		do @(posedge clk); while (!s_tready);
		p = schedule_step(fn, id, arr, len);
		if (known && p !== res) begin
			$error("table row disagrees with prediction: %h vs %h", res, p);
			errors++;
		end
		pending_res.push_back(known ? res : p);
	endtask

	// receiver: random stalls, a long hold-off on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_off) m_tready <= 1'b0;
			else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 7);
				repeat (n - 1) @(posedge clk);
			end else m_tready <= 1'b1;
		end
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_res.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				e = pending_res.pop_front();
				if (m_tuser[0] !== e.idle) begin
					$error("idle: expected %0d, got %0d", e.idle, m_tuser[0]); errors++;
				end
				if (m_tuser[1] !== e.rejected) begin
					$error("rejected: expected %0d, got %0d", e.rejected, m_tuser[1]);
					errors++;
				end
				if (m_tdata[15:0] !== e.run_id) begin
					$error("run_id: expected %0d, got %0d", e.run_id, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[55:16] !== e.wait_total) begin
					$error("wait_total: expected %0d, got %0d", e.wait_total,
						m_tdata[55:16]);
					errors++;
				end
				if (m_tdata[56 +: CW] !== e.occupancy) begin
					$error("occupancy: expected %0d, got %0d", e.occupancy,
						m_tdata[56 +: CW]);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		int i;
		int k;
		int burst;
		logic [15:0] id;
		njobs = 0; now_tick = '0; wait_acc = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; results typed only where obvious
		rows.push_back('{FN_TICK, 16'd0, 32'd0, 16'd1, 1, '{1'b1, 16'd0, 1'b0, 40'd0, 7'd0}});
		rows.push_back('{FN_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1,
			'{1'b0, 16'd0, 1'b0, 40'd0, 7'd1}});
		rows.push_back('{FN_ARRIVE, 16'h0000, 32'h0, 16'hFFFF, 1,
			'{1'b0, 16'd0, 1'b0, 40'd0, 7'd2}});
		// tie on length: lower id runs; arrival in the future adds no wait
		rows.push_back('{FN_TICK, 0, 0, 1, 0, '0});
		rows.push_back('{FN_ARRIVE, 16'd7, 32'd0, 16'd1, 0, '0});
		rows.push_back('{FN_ARRIVE, 16'd7, 32'd0, 16'd1, 0, '0}); // duplicate id
		rows.push_back('{FN_ARRIVE, 16'd9, 32'd0, 16'd0, 0, '0}); // zero length
		rows.push_back('{FN_ARRIVE, 16'h5555, 32'hAAAA_AAAA, 16'h5555, 0, '0});
		rows.push_back('{FN_ARRIVE, 16'hAAAA, 32'h5555_5555, 16'hAAAA, 0, '0});
		for (i = 0; i < 8; i++) rows.push_back('{FN_TICK, 0, 0, 1, 0, '0});
		foreach (rows[j]) begin
			row = rows[j];
			send_item(row.fn, row.id, row.arr, row.len, row.known, row.res);
		end
		drain();
		// empty the heap of the long jobs quickly is impossible; carry them on

		// fill the heap past capacity while the receiver holds off
		hold_off = 1;
		fork
			begin
				for (i = 0; i < CAP + 4; i++)
					send_item(FN_ARRIVE, 16'($urandom), now_tick - $urandom_range(0, 50),
						16'($urandom_range(1, 4)), 0, '0);
			end
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
		join
		drain();

		// random part: mostly short jobs so many finish, with bursts of ticks
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 200) calm = 1;
			if (i == N_RANDOM / 2) drain();
			if ($urandom_range(0, 99) < 45) begin
				id = 16'($urandom_range(0, 31));
				if ($urandom_range(0, 9) == 0) id = 16'($urandom);
				k = $urandom_range(0, 9);
				send_item(FN_ARRIVE, id,
					(k == 0) ? 32'($urandom) : now_tick - 32'($urandom_range(0, 20)),
					(k == 1) ? 16'($urandom) : 16'($urandom_range(0, 6)), 0, '0);
			end else begin
				burst = $urandom_range(1, 3);
				for (k = 0; k < burst; k++)
					send_item(FN_TICK, 16'($urandom), 32'($urandom), 16'($urandom), 0, '0);
			end
		end
		drain();
		repeat (60) @(posedge clk);
		if (errors == 0 && pending_res.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
